// ===== rtl/core/jtl_pkg.sv =====
// ----------------------------------------------------------------------------
// jtl_pkg
// Shared types and constants for the JSON token lexer: result kinds, error
// codes, character codes and the per-byte result bundle.
// ----------------------------------------------------------------------------
package jtl_pkg;

  typedef enum logic [3:0] {
    KIND_CONTENT   = 4'd0,
    KIND_OBJ_START = 4'd1,
    KIND_OBJ_END   = 4'd2,
    KIND_ARR_START = 4'd3,
    KIND_ARR_END   = 4'd4,
    KIND_COLON     = 4'd5,
    KIND_COMMA     = 4'd6,
    KIND_KEY       = 4'd7,
    KIND_STRING    = 4'd8,
    KIND_BOOL      = 4'd9,
    KIND_NULL      = 4'd10,
    KIND_NUMBER    = 4'd11,
    KIND_ERROR     = 4'd12,
    KIND_END       = 4'd13
  } lex_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNEXPECTED   = 3'd1,
    ERR_UNTERMINATED = 3'd2,
    ERR_TOO_LONG     = 3'd3,
    ERR_BAD_NUMBER   = 3'd4,
    ERR_BAD_LITERAL  = 3'd5
  } lex_err_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  localparam logic [31:0] LIT_TRUE  = "true";
  localparam logic [39:0] LIT_FALSE = "false";
  localparam logic [31:0] LIT_NULL  = "null";

  localparam logic [1:0] LIT_SEL_TRUE  = 2'd0;
  localparam logic [1:0] LIT_SEL_FALSE = 2'd1;
  localparam logic [1:0] LIT_SEL_NULL  = 2'd2;

  localparam logic [15:0]        POS_MAX   = 16'hFFFF;
  localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;
  localparam int                 MAX_RES   = 3;

  typedef struct packed {
    lex_kind_t             kind;
    logic [7:0]            content;
    lex_err_t              err;
    logic signed [15:0]    depth;
  } lex_rec_t;

  typedef struct packed {
    logic [1:0]            cnt;
    logic [15:0]           line;
    logic [15:0]           col;
    lex_rec_t [MAX_RES-1:0] rec;
  } lex_bundle_t;

endpackage

// ===== rtl/core/jtl_step.sv =====
// ----------------------------------------------------------------------------
// jtl_step
// Lexer state and the single-pass per-byte update that builds the bundle of
// up to three results for one transaction.
// ----------------------------------------------------------------------------
module jtl_step import jtl_pkg::*; #(
  parameter int MAX_CONTENT = 511
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        stream_last,
  output lex_bundle_t bundle
);

  localparam int CNT_W = $clog2(MAX_CONTENT + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CONTENT);

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_ESC, M_SDONE, M_NSIGN, M_NINT, M_NDOT, M_NFRAC,
    M_NE, M_NESIGN, M_NEXP, M_LIT
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [CNT_W-1:0]   cnt;
    logic [2:0]         lidx;
    logic [1:0]         lwhich;
    logic signed [15:0] depth;
    lex_bundle_t        bd;
  } ctx_t;

  mode_t              mode;
  logic [CNT_W-1:0]   cnt;
  logic [2:0]         lidx;
  logic [1:0]         lwhich;
  logic signed [15:0] depth;
  logic [15:0]        line;
  logic [15:0]        col;
  ctx_t               step;
  logic [1:0]         lit_w;

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_struct(input logic [7:0] b);
    return b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK ||
           b == CH_RBRACK || b == CH_COLON || b == CH_COMMA;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    return (w == LIT_SEL_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      LIT_SEL_FALSE: if (i < 3'd5) c = LIT_FALSE[39 - 8*i -: 8];
      LIT_SEL_NULL:  if (i < 3'd4) c = LIT_NULL[31 - 8*i -: 8];
      default:       if (i < 3'd4) c = LIT_TRUE[31 - 8*i -: 8];
    endcase
    return c;
  endfunction

  function automatic ctx_t f_emit(input ctx_t x, input lex_kind_t k,
                                  input logic [7:0] c, input lex_err_t e);
    ctx_t y;
    y = x;
    if (y.bd.cnt != 2'(MAX_RES)) begin
      y.bd.rec[y.bd.cnt].kind    = k;
      y.bd.rec[y.bd.cnt].content = c;
      y.bd.rec[y.bd.cnt].err     = e;
      y.bd.rec[y.bd.cnt].depth   = y.depth;
      y.bd.cnt = y.bd.cnt + 2'd1;
    end
    return y;
  endfunction

  function automatic ctx_t f_put(input ctx_t x, input logic [7:0] b);
    ctx_t y;
    y = x;
    if (y.cnt < CNT_LIMIT) begin
      y = f_emit(y, KIND_CONTENT, b, ERR_NONE);
      y.cnt = y.cnt + CNT_W'(1);
    end
    return y;
  endfunction

  function automatic ctx_t f_fail(input ctx_t x, input lex_err_t e);
    ctx_t y;
    y = f_emit(x, KIND_ERROR, 8'h00, e);
    y.mode = M_IDLE;
    y.cnt  = '0;
    return y;
  endfunction

  function automatic ctx_t f_idle(input ctx_t x, input logic [7:0] b);
    ctx_t y;
    y = x;
    y.mode = M_IDLE;
    y.cnt  = '0;
    if (!is_blank(b)) begin
      case (b)
        CH_LBRACE: begin
          if (y.depth != DEPTH_MAX) y.depth = y.depth + 16'sd1;
          y = f_emit(y, KIND_OBJ_START, 8'h00, ERR_NONE);
        end
        CH_LBRACK: begin
          if (y.depth != DEPTH_MAX) y.depth = y.depth + 16'sd1;
          y = f_emit(y, KIND_ARR_START, 8'h00, ERR_NONE);
        end
        CH_RBRACE: begin
          if (y.depth != DEPTH_MIN) y.depth = y.depth - 16'sd1;
          y = f_emit(y, KIND_OBJ_END, 8'h00, ERR_NONE);
        end
        CH_RBRACK: begin
          if (y.depth != DEPTH_MIN) y.depth = y.depth - 16'sd1;
          y = f_emit(y, KIND_ARR_END, 8'h00, ERR_NONE);
        end
        CH_COLON: y = f_emit(y, KIND_COLON, 8'h00, ERR_NONE);
        CH_COMMA: y = f_emit(y, KIND_COMMA, 8'h00, ERR_NONE);
        CH_QUOTE: y.mode = M_STR;
        CH_LOW_T, CH_LOW_F, CH_LOW_N: begin
          y.lwhich = (b == CH_LOW_T) ? LIT_SEL_TRUE :
                     (b == CH_LOW_F) ? LIT_SEL_FALSE : LIT_SEL_NULL;
          y.lidx = 3'd1;
          y = f_put(y, b);
          y.mode = M_LIT;
        end
        default: begin
          if (b == CH_MINUS || is_numeral(b)) begin
            y = f_put(y, b);
            y.mode = (b == CH_MINUS) ? M_NSIGN : M_NINT;
          end else begin
            y = f_fail(y, ERR_UNEXPECTED);
          end
        end
      endcase
    end
    return y;
  endfunction

  function automatic ctx_t f_follow(input ctx_t x, input lex_kind_t k,
                                    input logic [7:0] b);
    ctx_t y;
    y = f_emit(x, k, 8'h00, ERR_NONE);
    y.mode = M_IDLE;
    y.cnt  = '0;
    if (is_blank(b) || is_struct(b)) y = f_idle(y, b);
    else y = f_fail(y, ERR_UNEXPECTED);
    return y;
  endfunction

  assign lit_w = (lwhich == 2'd3) ? LIT_SEL_TRUE : lwhich;

  always_comb begin
    logic [7:0] b;
    logic       dig;
    logic       ech;
    b   = data_byte;
    dig = is_numeral(b);
    ech = (b == CH_LOW_E) || (b == CH_UP_E);
    step        = '0;
    step.mode   = mode;
    step.cnt    = cnt;
    step.lidx   = lidx;
    step.lwhich = lwhich;
    step.depth  = depth;
    step.bd.line = line;
    step.bd.col  = col;
    case (mode)
      M_STR: begin
        if (b == CH_QUOTE) step.mode = M_SDONE;
        else if (b == CH_BSLASH) step.mode = M_ESC;
        else if (cnt < CNT_LIMIT) step = f_put(step, b);
        else step = f_fail(step, ERR_TOO_LONG);
      end
      M_ESC: begin
        step = f_put(step, b);
        step.mode = M_STR;
      end
      M_SDONE: begin
        if (is_blank(b)) begin
          step.mode = M_SDONE;
        end else if (b == CH_COLON) begin
          step = f_emit(step, KIND_KEY, 8'h00, ERR_NONE);
          step = f_idle(step, b);
        end else begin
          step = f_follow(step, KIND_STRING, b);
        end
      end
      M_LIT: begin
        if (lidx < lit_len(lit_w) && b == lit_char(lit_w, lidx)) begin
          step = f_put(step, b);
          step.lidx = lidx + 3'd1;
          if ({1'b0, lidx} + 4'd1 >= {1'b0, lit_len(lit_w)}) begin
            step = f_emit(step, (lit_w == LIT_SEL_NULL) ? KIND_NULL : KIND_BOOL,
                          8'h00, ERR_NONE);
            step.mode = M_IDLE;
            step.cnt  = '0;
          end
        end else begin
          step = f_fail(step, ERR_BAD_LITERAL);
        end
      end
      M_NSIGN, M_NDOT, M_NESIGN: begin
        if (dig) begin
          step = f_put(step, b);
          step.mode = (mode == M_NSIGN) ? M_NINT :
                      (mode == M_NDOT) ? M_NFRAC : M_NEXP;
        end else begin
          step = f_fail(step, ERR_BAD_NUMBER);
        end
      end
      M_NE: begin
        if (dig) begin
          step = f_put(step, b);
          step.mode = M_NEXP;
        end else if (b == CH_PLUS || b == CH_MINUS) begin
          step = f_put(step, b);
          step.mode = M_NESIGN;
        end else begin
          step = f_fail(step, ERR_BAD_NUMBER);
        end
      end
      M_NINT: begin
        if (dig) step = f_put(step, b);
        else if (b == CH_DOT) begin
          step = f_put(step, b);
          step.mode = M_NDOT;
        end else if (ech) begin
          step = f_put(step, b);
          step.mode = M_NE;
        end else step = f_follow(step, KIND_NUMBER, b);
      end
      M_NFRAC: begin
        if (dig) step = f_put(step, b);
        else if (ech) begin
          step = f_put(step, b);
          step.mode = M_NE;
        end else step = f_follow(step, KIND_NUMBER, b);
      end
      M_NEXP: begin
        if (dig) step = f_put(step, b);
        else step = f_follow(step, KIND_NUMBER, b);
      end
      default: step = f_idle(step, b);
    endcase

    if (stream_last) begin
      if (step.mode inside {M_STR, M_ESC}) step = f_fail(step, ERR_UNTERMINATED);
      else if (step.mode == M_LIT) step = f_fail(step, ERR_BAD_LITERAL);
      else if (step.mode inside {M_NSIGN, M_NDOT, M_NE, M_NESIGN})
        step = f_fail(step, ERR_BAD_NUMBER);
      else if (step.mode inside {M_NINT, M_NFRAC, M_NEXP})
        step = f_emit(step, KIND_NUMBER, 8'h00, ERR_NONE);
      else if (step.mode == M_SDONE)
        step = f_emit(step, KIND_STRING, 8'h00, ERR_NONE);
      step = f_emit(step, KIND_END, 8'h00, ERR_NONE);
    end
  end

  assign bundle = step.bd;

  always_ff @(posedge clk) begin
    if (rst || (take && stream_last)) begin
      mode   <= M_IDLE;
      cnt    <= '0;
      lidx   <= 3'd0;
      lwhich <= LIT_SEL_TRUE;
      depth  <= 16'sd0;
      line   <= 16'd1;
      col    <= 16'd1;
    end else if (take) begin
      mode   <= step.mode;
      cnt    <= step.cnt;
      lidx   <= step.lidx;
      lwhich <= step.lwhich;
      depth  <= step.depth;
      if (data_byte == CH_LF) begin
        col <= 16'd1;
        if (line != POS_MAX) line <= line + 16'd1;
      end else if (col != POS_MAX) begin
        col <= col + 16'd1;
      end
    end
  end

endmodule

// ===== rtl/core/jtl_out.sv =====
// ----------------------------------------------------------------------------
// jtl_out
// Result register: holds one transaction's bundle and hands its results out
// one per cycle while out_stall is low, marking the last one.
// ----------------------------------------------------------------------------
module jtl_out import jtl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  lex_bundle_t        bundle,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic [7:0]         content,
  output logic [2:0]         error_code,
  output logic [15:0]        line_number,
  output logic [15:0]        column_number,
  output logic signed [15:0] nest_depth,
  output logic               run_end
);

  lex_bundle_t bd;
  logic [1:0]  idx;
  logic        valid;
  logic        last;
  logic        send;

  assign last = (idx == bd.cnt - 2'd1);
  assign send = valid && !out_stall;
  assign busy = valid && !(send && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (take && bundle.cnt != 2'd0) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (send) begin
      if (last) valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && bundle.cnt != 2'd0) bd <= bundle;
  end

  assign out_valid     = valid;
  assign kind          = bd.rec[idx].kind;
  assign content       = bd.rec[idx].content;
  assign error_code    = bd.rec[idx].err;
  assign line_number   = bd.line;
  assign column_number = bd.col;
  assign nest_depth    = bd.rec[idx].depth;
  assign run_end       = last;

endmodule

// ===== rtl/core/json_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// json_token_lexer_core
// Streaming JSON lexer, one text byte per transaction.
// The first result of a byte appears in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
//   and out_stall is low; a byte with more results (up to 3) stalls the input
//   until the single result register drains them, one per cycle without stall.
// Reset: synchronous; clears the lexer to idle, line and column to 1, depth
//   to 0, and empties the result register.
// ----------------------------------------------------------------------------
module json_token_lexer_core import jtl_pkg::*; #(
  parameter int MAX_CONTENT = 511
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               stream_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic [7:0]         content,
  output logic [2:0]         error_code,
  output logic [15:0]        line_number,
  output logic [15:0]        column_number,
  output logic signed [15:0] nest_depth,
  output logic               run_end
);

  lex_bundle_t bundle;
  logic        busy;
  logic        take;

  assign in_stall = busy;
  assign take     = in_valid && !busy;

  jtl_step #(.MAX_CONTENT(MAX_CONTENT)) u_step (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .stream_last (stream_last),
    .bundle      (bundle)
  );

  jtl_out u_out (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .bundle        (bundle),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .content       (content),
    .error_code    (error_code),
    .line_number   (line_number),
    .column_number (column_number),
    .nest_depth    (nest_depth),
    .run_end       (run_end)
  );

endmodule

// ===== rtl/core/jtl_check.sv =====
// ----------------------------------------------------------------------------
// jtl_check
// Port-level checks for the JSON token lexer, bound to the top level.
// ----------------------------------------------------------------------------
module jtl_check import jtl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         kind,
  input logic [7:0]         content,
  input logic [2:0]         error_code,
  input logic               run_end
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(content))
    else $error("stalled transaction changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_content_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CONTENT |-> content == 8'h00)
    else $error("content set on a non-content result");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END |-> run_end)
    else $error("end result not last of its byte");

endmodule

bind json_token_lexer_core jtl_check u_check (.*);
